// ===== rtl/dual_lfsr_xor_stream_cipher_core_macros.svh =====
// Assertion helpers for the stream cipher core.
`ifndef DUAL_LFSR_XOR_STREAM_CIPHER_CORE_MACROS_SVH
`define DUAL_LFSR_XOR_STREAM_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define DLX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlx assertion failed: same-cycle check");

// Next-cycle implication, checked only outside reset.
`define DLX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlx assertion failed: next-cycle check");

`endif

// ===== rtl/dlx_pkg.sv =====
`timescale 1ns / 1ps
package dlx_pkg;

  // Combined generator state: A is 32 bits, B is 128 bits.
  typedef struct packed {
    logic [31:0]  a;
    logic [127:0] b;
  } state_t;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [63:0] cfg_data_t;

  localparam cfg_idx_t REG_SEED_A      = 2'd0;
  localparam cfg_idx_t REG_SEED_B_LOW  = 2'd1;
  localparam cfg_idx_t REG_SEED_B_HIGH = 2'd2;

  localparam logic [31:0] SEED_A_RST      = 32'h007b_3c1a;
  localparam logic [63:0] SEED_B_LOW_RST  = 64'h7e8f_9a0b_003b_2c1d;
  localparam logic [63:0] SEED_B_HIGH_RST = 64'h1a2b_3c4a_5c6d_7e8f;

  localparam int A_TAP_HI = 6;
  localparam int A_TAP_LO = 3;
  localparam int A_INSERT = 22;
  localparam int B_TAP_LO = 111;
  localparam int B_TAP_HI = 119;
  localparam int B_INSERT = 118;

  localparam int KEY_BITS = 8;

endpackage

// ===== rtl/dlx_if.sv =====
`timescale 1ns / 1ps
// Input item channel: one byte to be masked.
interface dlx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

// Result item channel: masked byte and the keystream byte used.
interface dlx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic [7:0] key_byte;

  modport source (output valid, output cipher_byte, output key_byte, input ready);
  modport sink   (input valid, input cipher_byte, input key_byte, output ready);
endinterface

// ===== rtl/dlx_keygen.sv =====
`timescale 1ns / 1ps
module dlx_keygen (
  input  dlx_pkg::state_t st_i,
  output dlx_pkg::state_t st_o,
  output logic [7:0]      key_o
);
  import dlx_pkg::*;

  // Eight unrolled bit steps of both registers. Feedback is ORed into the
  // insert position after the shift, exactly as the original scheme does.
  always_comb begin
    logic [31:0]  a;
    logic [127:0] b;
    logic         fa;
    logic         fb;
    a = st_i.a;
    b = st_i.b;
    key_o = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      fa = a[A_TAP_HI] ^ a[A_TAP_LO];
      a  = (a >> 1) | ({31'd0, fa} << A_INSERT);
      fb = b[B_TAP_LO] ^ b[B_TAP_HI];
      b  = (b >> 1) | ({127'd0, fb} << B_INSERT);
      key_o[KEY_BITS - 1 - i] = a[0] ^ b[0];
    end
    st_o.a = a;
    st_o.b = b;
  end

endmodule

// ===== rtl/dual_lfsr_xor_stream_cipher_core.sv =====
`timescale 1ns / 1ps
// Byte stream masker built from two shift-register generators.
// The in_chan channel takes one byte per item; the out_chan channel returns
// the byte XORed with a keystream byte, together with that keystream byte.
// Both channels use a valid/ready handshake; an item moves on an edge where
// both are high. The generator state advances by eight bit steps at the edge
// an item is accepted, so items are masked strictly in order.
// An item accepted from in_chan passes through the input register and then
// the output register before it can be taken from out_chan. Throughput is one
// item per cycle while the receiver does not stall, set by the single unrolled
// eight-step keystream block ahead of the input register. The input register
// and the output register form a two-entry pipeline; when the receiver stalls,
// both fill and in_chan.ready drops only once both hold an item.
// The cfg port writes seed registers (0: seed A, 1: B bits 63..0,
// 2: B bits 127..64). Any valid seed write reloads the whole generator from
// the seeds; other indexes are ignored. Writes belong to idle periods.
// Synchronous reset restores the default seeds, loads the generator from
// them and empties the pipeline.
module dual_lfsr_xor_stream_cipher_core (
  input  logic                clk,
  input  logic                rst_n,
  dlx_in_if.sink              in_chan,
  dlx_out_if.source           out_chan,
  input  logic                cfg_we,
  input  dlx_pkg::cfg_idx_t   cfg_index,
  input  dlx_pkg::cfg_data_t  cfg_wdata
);
  import dlx_pkg::*;
  `include "dual_lfsr_xor_stream_cipher_core_macros.svh"

  // Seed registers and their next values.
  logic [31:0] seed_a_r, seed_a_nxt;
  logic [63:0] seed_bl_r, seed_bl_nxt;
  logic [63:0] seed_bh_r, seed_bh_nxt;
  logic        seed_load;

  // Generator state.
  state_t st_r, st_nxt, st_adv;
  logic [7:0] key_comb;

  // Input stage holds the byte and its keystream byte.
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_plain_r, s1_key_r;

  // Output stage.
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_cipher_r, out_key_r;

  logic in_acc;
  logic s1_adv;
  logic out_free;

  // Seed decode. Only the three defined indexes store and reload.
  always_comb begin
    seed_a_nxt  = seed_a_r;
    seed_bl_nxt = seed_bl_r;
    seed_bh_nxt = seed_bh_r;
    seed_load   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_A: begin
          seed_a_nxt = cfg_wdata[31:0];
          seed_load  = 1'b1;
        end
        REG_SEED_B_LOW: begin
          seed_bl_nxt = cfg_wdata;
          seed_load   = 1'b1;
        end
        REG_SEED_B_HIGH: begin
          seed_bh_nxt = cfg_wdata;
          seed_load   = 1'b1;
        end
        default: begin
          seed_load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r  <= SEED_A_RST;
      seed_bl_r <= SEED_B_LOW_RST;
      seed_bh_r <= SEED_B_HIGH_RST;
    end else begin
      seed_a_r  <= seed_a_nxt;
      seed_bl_r <= seed_bl_nxt;
      seed_bh_r <= seed_bh_nxt;
    end
  end

  dlx_keygen u_keygen (
    .st_i  (st_r),
    .st_o  (st_adv),
    .key_o (key_comb)
  );

  // Handshake. The output register empties when the receiver takes it,
  // and the input stage moves forward whenever the output has room.
  assign out_free       = !out_vld_r || out_chan.ready;
  assign s1_adv         = s1_vld_r && out_free;
  assign in_chan.ready  = !s1_vld_r || out_free;
  assign in_acc         = in_chan.valid && in_chan.ready;

  // A seed write reloads the generator; an accepted item advances it.
  always_comb begin
    st_nxt = st_r;
    if (seed_load) begin
      st_nxt.a = seed_a_nxt;
      st_nxt.b = {seed_bh_nxt, seed_bl_nxt};
    end else if (in_acc) begin
      st_nxt = st_adv;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.a    <= SEED_A_RST;
      st_r.b    <= {SEED_B_HIGH_RST, SEED_B_LOW_RST};
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_plain_r <= in_chan.plain_byte;
      s1_key_r   <= key_comb;
    end
    if (s1_adv) begin
      out_cipher_r <= s1_plain_r ^ s1_key_r;
      out_key_r    <= s1_key_r;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.cipher_byte = out_cipher_r;
  assign out_chan.key_byte    = out_key_r;

  // Back pressure reaches the input only when both stages are full.
  `DLX_ASSERT_NOW(a_ready_full, clk, rst_n, !in_chan.ready, s1_vld_r && out_vld_r)
  // A seed write leaves the generator equal to the stored seeds.
  `DLX_ASSERT_NEXT(a_seed_reload, clk, rst_n, seed_load,
                   st_r.a == seed_a_r && st_r.b == {seed_bh_r, seed_bl_r})
  // A held input stage keeps its keystream byte while the output is blocked.
  `DLX_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_vld_r && !out_free,
                   s1_vld_r && $stable(s1_key_r) && $stable(s1_plain_r))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the dual shift-register stream cipher core.
// A local model of both generators predicts the cipher byte and the
// keystream byte for every item the core accepts. The receiver process
// compares each result item against the oldest prediction. Seed writes happen
// only while the pipeline is empty, so the model and the core reload together.
module tb;
  import dlx_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int MAX_IDLE    = 13;
  localparam int PIPE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;

  // Index 3 is outside the register map, so the core must ignore it.
  localparam cfg_idx_t REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [7:0] key_byte;
  } mask_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_wdata;

  dlx_in_if  in_chan ();
  dlx_out_if out_chan ();

  dual_lfsr_xor_stream_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model copy of the seed registers and of the running generator state.
  logic [31:0]  seed_a_m;
  logic [63:0]  seed_b_low_m;
  logic [63:0]  seed_b_high_m;
  logic [31:0]  gen_a;
  logic [127:0] gen_b;

  mask_result_t pending_results[$];
  int fail_count;

  // Knobs that the tests turn to shape the traffic on both channels.
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("[dual_lfsr_xor_stream_cipher_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------

  function automatic void reload_generator();
    gen_a = seed_a_m;
    gen_b = {seed_b_high_m, seed_b_low_m};
  endfunction

  function automatic void restore_default_seeds();
    seed_a_m      = SEED_A_RST;
    seed_b_low_m  = SEED_B_LOW_RST;
    seed_b_high_m = SEED_B_HIGH_RST;
    reload_generator();
  endfunction

  // A write to any mapped seed register reloads the whole generator; a write
  // to an unmapped index leaves both the seeds and the running state alone.
  function automatic void apply_seed_write(input cfg_idx_t idx, input cfg_data_t val);
    case (idx)
      REG_SEED_A: begin
        seed_a_m = val[31:0];
      end
      REG_SEED_B_LOW: begin
        seed_b_low_m = val;
      end
      REG_SEED_B_HIGH: begin
        seed_b_high_m = val;
      end
      default: begin
        return;
      end
    endcase
    reload_generator();
  endfunction

  // Eight bit steps per byte. The feedback is ORed into the insert position
  // rather than shifted in at the top, which is the intended behavior.
  // The first bit produced ends up in bit 7 of the keystream byte.
  function automatic mask_result_t mask_byte(input logic [7:0] plain);
    mask_result_t res;
    logic fa;
    logic fb;
    logic [7:0] key;
    key = 8'h00;
    for (int i = 0; i < KEY_BITS; i++) begin
      fa = gen_a[A_TAP_HI] ^ gen_a[A_TAP_LO];
      fb = gen_b[B_TAP_LO] ^ gen_b[B_TAP_HI];
      gen_a = (gen_a >> 1) | (32'(fa) << A_INSERT);
      gen_b = (gen_b >> 1) | (128'(fb) << B_INSERT);
      key = {key[6:0], gen_a[0] ^ gen_b[0]};
    end
    res.key_byte    = key;
    res.cipher_byte = plain ^ key;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------

  // Offers one item and returns right after the edge that accepted it.
  // Valid is only lowered when a gap is drawn, so back-to-back items keep
  // valid high without a glitch in the same time step.
  task automatic send_byte(input logic [7:0] plain);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.plain_byte <= plain;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(mask_byte(plain));
  endtask

  // Stops offering items and waits until every predicted result has been
  // taken, then lets the pipeline settle.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // Seed writes are only issued with the pipeline empty.
  task automatic write_seed(input cfg_idx_t idx, input cfg_data_t val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_seed_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cfg_data_t pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------

  task automatic check_result(input logic [7:0] cipher, input logic [7:0] key);
    mask_result_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result item cipher=%h key=%h", $time, cipher, key);
      fail_count++;
      return;
    end
    exp = pending_results.pop_front();
    if (cipher !== exp.cipher_byte) begin
      $display("%0t: cipher_byte expected %h actual %h", $time, exp.cipher_byte, cipher);
      fail_count++;
    end
    if (key !== exp.key_byte) begin
      $display("%0t: key_byte expected %h actual %h", $time, exp.key_byte, key);
      fail_count++;
    end
  endtask

  // The receiver draws a stall before each item. A hold request from a test
  // replaces one stall with a long stretch so that both pipeline registers
  // fill and the core has to drop its input ready.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      check_result(out_chan.cipher_byte, out_chan.key_byte);
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // The default seeds are active straight out of reset. Corner bytes on the
  // input side show that the keystream is applied to every bit position.
  task automatic test_reset_seeds();
    logic [7:0] corners[6];
    corners = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80};
    foreach (corners[i]) send_byte(corners[i]);
  endtask

  // Seed A gets both extremes, B low all ones and B high zero. The seed A write
  // carries junk in the upper half of the data word, which must be dropped.
  task automatic test_seed_writes();
    write_seed(REG_SEED_A, {$urandom(), 32'h0000_0000});
    send_byte(8'h3c);
    send_byte(8'hc3);
    write_seed(REG_SEED_A, {$urandom(), 32'hffff_ffff});
    send_byte(8'h0f);
    send_byte(8'hf0);
    write_seed(REG_SEED_B_LOW, '1);
    send_byte(8'h12);
    send_byte(8'hed);
    write_seed(REG_SEED_B_HIGH, '0);
    send_byte(8'h7f);
    send_byte(8'hfe);
  endtask

  // A write to the unmapped index must neither change a seed nor restart
  // the generator, so the keystream carries on from where it was.
  task automatic test_unmapped_index();
    send_byte(8'h21);
    send_byte(8'hde);
    write_seed(REG_UNMAPPED, {$urandom(), $urandom()});
    send_byte(8'h99);
    send_byte(8'h66);
  endtask

  // With all seeds cleared both generators stay at zero and the keystream
  // is zero, so every byte passes through unchanged.
  task automatic test_zero_seeds();
    write_seed(REG_SEED_A, '0);
    write_seed(REG_SEED_B_LOW, '0);
    write_seed(REG_SEED_B_HIGH, '0);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'ha5);
  endtask

  // Random seeds, random bytes and random idling on both sides. One phase
  // runs without any idling so the core sees one item per cycle.
  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      write_seed(REG_SEED_A, pick_seed());
      write_seed(REG_SEED_B_LOW, pick_seed());
      write_seed(REG_SEED_B_HIGH, pick_seed());
      tx_idle_en = (phase != 3);
      rx_idle_en = (phase != 3);
      repeat (140) send_byte(8'($urandom()));
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items back to back, so the core fills up and stalls its input.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_en   = 1'b0;
    hold_request = 1'b1;
    repeat (60) send_byte(8'($urandom()));
    tx_idle_en = 1'b1;
  endtask

  // The sender stops in the middle of a stream until every result is back,
  // then resumes without reseeding.
  task automatic test_sender_pause();
    repeat (20) send_byte(8'($urandom()));
    wait_idle();
    repeat (20) send_byte(8'($urandom()));
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SEED_A;
    cfg_wdata          <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.plain_byte <= 8'h00;
    out_chan.ready     <= 1'b0;
    fail_count   = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_request = 1'b0;
    restore_default_seeds();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_seeds();
    test_seed_writes();
    test_unmapped_index();
    test_zero_seeds();
    test_random_stream();
    test_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (PIPE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[dual_lfsr_xor_stream_cipher_core] OK");
    end else begin
      $display("[dual_lfsr_xor_stream_cipher_core] ERROR");
    end
    $finish;
  end
endmodule
